// ===== hw/rtl/xas_pkg.sv =====
`default_nettype none

package xas_pkg;

  // Store geometry
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Generator
  localparam logic [31:0] SEED_RESET = 32'd2463534242;
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;

  // Remainder unit: one quotient bit per cycle over the 32-bit dividend
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,  // taking elements
    ST_RNG,   // advance generator, launch remainder
    ST_DIV,   // wait for remainder, read element i
    ST_RDR,   // read element r, hold element i
    ST_WRI,   // write element r into slot i
    ST_WRR,   // write held element i into slot r
    ST_ERD,   // read next element to emit
    ST_ELD    // load output register
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/xas_ram.sv =====
`default_nettype none

module xas_ram #(
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/xas_remu.sv =====
`default_nettype none

// Restoring remainder: dividend mod divisor, one dividend bit per cycle.
// The divisor never exceeds DEPTH, so the partial remainder fits CNT_W bits.
module xas_remu import xas_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [31:0]      dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [CNT_W-1:0] rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [31:0]       dvd_q, dvd_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_STEPS - 1);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = CNT_W'(trial);
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/xorshift_array_shuffle.sv =====
`default_nettype none

// Collects up to DEPTH signed 32-bit elements, one per input transaction,
// until an element marked last arrives; elements past DEPTH are discarded
// and every result of that set carries dropped. The set is then shuffled
// in place in a single-port-read element RAM by a forward Fisher-Yates
// pass driven by a xorshift32 generator, and emitted in order with last_res
// on the final element. Each shuffled position takes one generator step, a
// pass through the bit-serial remainder unit, RAM reads of both elements
// and two RAM writes for the swap. Each element is emitted by a RAM read,
// then a load of the output register, which waits while a held result is
// stalled. Input is stalled from the last element until the final result
// is loaded into the output register. Writing the seed register loads the
// generator; its state otherwise carries over from set to set.
module xorshift_array_shuffle import xas_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // element input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  // seed register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;     // elements stored
  logic [CNT_W-1:0] idx_q, idx_d;     // shuffle position / emit position
  logic [IDX_W-1:0] r_q, r_d;         // swap partner
  logic [31:0]      tmp_q, tmp_d;     // held element i
  logic [31:0]      gen_q, gen_d;
  logic             ovf_q, ovf_d;
  logic             oval_q, oval_d;
  out_item_t        out_q, out_d;

  logic             in_acc;
  logic             full;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      gen_next;
  logic             rem_start;
  logic             rem_done;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] idx_inc;
  logic             idx_end;
  logic             slot_free;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  function automatic logic [31:0] xs_step(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign full        = (cnt_q == CNT_W'(DEPTH));
  assign cnt_inc     = cnt_q + CNT_W'(1);
  assign gen_next    = xs_step(gen_q);
  assign idx_inc     = idx_q + CNT_W'(1);
  assign idx_end     = (idx_inc == cnt_q);
  assign slot_free   = !oval_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_acc && in_data_i.last) state_d = ST_RNG;
      ST_RNG:  state_d = ST_DIV;
      ST_DIV:  if (rem_done) state_d = ST_RDR;
      ST_RDR:  state_d = ST_WRI;
      ST_WRI:  state_d = ST_WRR;
      ST_WRR:  state_d = idx_end ? ST_ERD : ST_RNG;
      ST_ERD:  if (slot_free) state_d = ST_ELD;
      ST_ELD:  state_d = idx_end ? ST_LOAD : ST_ERD;
      default: state_d = ST_LOAD;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    r_d       = r_q;
    tmp_d     = tmp_q;
    gen_d     = gen_q;
    ovf_d     = ovf_q;
    out_d     = out_q;
    oval_d    = oval_q && out_stall_i;
    rem_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[IDX_W-1:0];
    ram_wdata = in_data_i.value;
    ram_raddr = idx_q[IDX_W-1:0];
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_inc;
          end
          idx_d = '0;
        end
      end
      ST_RNG: begin
        gen_d     = gen_next;
        rem_start = 1'b1;
      end
      ST_DIV: begin
        r_d = idx_q[IDX_W-1:0] + rem[IDX_W-1:0];
      end
      ST_RDR: begin
        ram_raddr = r_q;
        tmp_d     = ram_rdata;
      end
      ST_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      ST_WRR: begin
        ram_we    = 1'b1;
        ram_waddr = r_q;
        ram_wdata = tmp_q;
        idx_d     = idx_end ? '0 : idx_inc;
      end
      ST_ERD: ;
      ST_ELD: begin
        out_d.value_res = ram_rdata;
        out_d.last_res  = idx_end;
        out_d.dropped   = ovf_q;
        oval_d          = 1'b1;
        idx_d           = idx_inc;
        if (idx_end) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          idx_d = '0;
        end
      end
      default: ;
    endcase
    // seed write takes priority over a generator step
    if (cfg_valid_i && cfg_ready_o) begin
      gen_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      gen_q   <= SEED_RESET;
      ovf_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      gen_q   <= gen_d;
      ovf_q   <= ovf_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    tmp_q <= tmp_d;
    out_q <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;

  // Element store
  xas_ram #(
    .AddrW(IDX_W),
    .DataW(32)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Swap offset: x mod (count - i)
  xas_remu u_remu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (gen_next),
    .divisor_i  (cnt_q - idx_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

endmodule

`default_nettype wire
